// ===== rtl/lom_pkg.sv =====
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types, constants and helpers of the limit order matcher: book
// geometry, report codes, the book entry layout and the controller states.
// ----------------------------------------------------------------------------
package lom_pkg;

	// book geometry
	localparam int BOOK_DEPTH      = 16;
	localparam int NUM_INSTRUMENTS = 5;
	localparam int MAX_RESULTS     = 32;
	localparam int NBOOKS          = 2 * NUM_INSTRUMENTS;
	localparam int NENTRIES        = NBOOKS * BOOK_DEPTH;

	localparam int SLOT_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int FILL_W = $clog2(BOOK_DEPTH + 1);
	localparam int BOOK_W = $clog2(NBOOKS);
	localparam int ADDR_W = $clog2(NENTRIES);
	localparam int RES_W  = $clog2(MAX_RESULTS + 1);

	// configuration
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_QTY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_QTY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOT     = 2'd2;
	localparam logic [CFG_W-1:0] MIN_QTY_RST = 15'd10;
	localparam logic [CFG_W-1:0] MAX_QTY_RST = 15'd1000;
	localparam logic [CFG_W-1:0] LOT_RST     = 15'd10;

	// remainder unit
	localparam int REM_CNT_W = $clog2(CFG_W + 1);

	// sides
	localparam logic [7:0] SIDE_BUY  = 8'd1;
	localparam logic [7:0] SIDE_SELL = 8'd2;

	typedef enum logic [1:0] {
		ST_NEW    = 2'd0,
		ST_FILL   = 2'd1,
		ST_PFILL  = 2'd2,
		ST_REJECT = 2'd3
	} exec_status_t;

	typedef enum logic [2:0] {
		RSN_NONE       = 3'd0,
		RSN_INSTRUMENT = 3'd1,
		RSN_SIDE       = 3'd2,
		RSN_QUANTITY   = 3'd3,
		RSN_PRICE      = 3'd4,
		RSN_BOOK_FULL  = 3'd5
	} reject_reason_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_INS_RD,
		S_INS_CHK,
		S_INS_NEW,
		S_MATCH_RD,
		S_MATCH_CHK,
		S_MATCH_UPD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic signed [31:0] price;
		logic signed [15:0] qty;
		logic [31:0]        serial;
		logic [31:0]        client;
		logic [63:0]        stamp;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic [31:0]        serial;
		logic [31:0]        client;
		logic [2:0]         instr;
		logic [7:0]         side;
		exec_status_t       status;
		logic signed [15:0] qty;
		logic signed [31:0] price;
		logic [63:0]        stamp;
		reject_reason_t     reason;
		logic               last;
	} report_t;

	// slot k places behind base in a circular book
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
			input logic [SLOT_W-1:0] k);
		int s;
		s = int'(base) + int'(k);
		if (s >= BOOK_DEPTH) s = s - BOOK_DEPTH;
		return SLOT_W'(s);
	endfunction

	// memory address of a slot of a book
	function automatic logic [ADDR_W-1:0] entry_addr(input logic [BOOK_W-1:0] b,
			input logic [SLOT_W-1:0] s);
		return ADDR_W'(int'(b) * BOOK_DEPTH + int'(s));
	endfunction

endpackage

// ===== rtl/lom_if.sv =====
// ----------------------------------------------------------------------------
// lom_if
// Channel interfaces of the limit order matcher: orders in, reports out and
// configuration writes.
// ----------------------------------------------------------------------------
interface lom_order_if;
	logic               valid;
	logic               ready;
	logic [31:0]        client_tag;
	logic [2:0]         instrument_code;
	logic [7:0]         order_side;
	logic signed [15:0] order_quantity;
	logic signed [31:0] limit_price;
	logic [63:0]        timestamp;

	modport source(output valid, client_tag, instrument_code, order_side,
		order_quantity, limit_price, timestamp, input ready);
	modport sink(input valid, client_tag, instrument_code, order_side,
		order_quantity, limit_price, timestamp, output ready);
endinterface

interface lom_report_if;
	logic               valid;
	logic               ready;
	logic [31:0]        serial_number;
	logic [31:0]        client_out;
	logic [2:0]         instrument_out;
	logic [7:0]         side_out;
	logic [1:0]         exec_status;
	logic signed [15:0] report_quantity;
	logic signed [31:0] report_price;
	logic [63:0]        time_out;
	logic [2:0]         reject_reason;
	logic               last_report;

	modport source(output valid, serial_number, client_out, instrument_out, side_out,
		exec_status, report_quantity, report_price, time_out, reject_reason,
		last_report, input ready);
	modport sink(input valid, serial_number, client_out, instrument_out, side_out,
		exec_status, report_quantity, report_price, time_out, reject_reason,
		last_report, output ready);
endinterface

interface lom_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lom_pkg::CFG_IDX_W-1:0] index;
	logic [lom_pkg::CFG_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/lom_mem.sv =====
// ----------------------------------------------------------------------------
// lom_mem
// Book entry memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module lom_mem (
	input  logic             clk,
	input  lom_pkg::mem_wr_t wr,
	input  lom_pkg::mem_rd_t rd_a,
	input  lom_pkg::mem_rd_t rd_b,
	output lom_pkg::entry_t  data_a,
	output lom_pkg::entry_t  data_b
);

	lom_pkg::entry_t mem_q [lom_pkg::NENTRIES];
	lom_pkg::entry_t rd_a_q;
	lom_pkg::entry_t rd_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) mem_q[wr.addr] <= wr.data;
	end

	// read ports, data held between reads
	always_ff @(posedge clk) begin
		if (rd_a.en) rd_a_q <= mem_q[rd_a.addr];
		if (rd_b.en) rd_b_q <= mem_q[rd_b.addr];
	end

	assign data_a = rd_a_q;
	assign data_b = rd_b_q;

endmodule

// ===== rtl/lom_rem.sv =====
// ----------------------------------------------------------------------------
// lom_rem
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lom_rem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lom_pkg::CFG_W-1:0] dividend,
	input  logic [lom_pkg::CFG_W-1:0] divisor,
	output logic                      busy,
	output logic [lom_pkg::CFG_W-1:0] remainder
);

	logic [lom_pkg::REM_CNT_W-1:0] cnt_q;
	logic [lom_pkg::CFG_W:0]       rem_q;
	logic [lom_pkg::CFG_W-1:0]     dvd_q;
	logic [lom_pkg::CFG_W:0]       trial;

	// shifted partial remainder
	assign trial = {rem_q[lom_pkg::CFG_W-1:0], dvd_q[lom_pkg::CFG_W-1]};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= lom_pkg::REM_CNT_W'(lom_pkg::CFG_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, divisor}) rem_q <= trial - {1'b0, divisor};
			else rem_q <= trial;
		end
	end

	assign busy      = (cnt_q != '0);
	assign remainder = rem_q[lom_pkg::CFG_W-1:0];

endmodule

// ===== rtl/limit_order_matcher.sv =====
// ----------------------------------------------------------------------------
// limit_order_matcher
// Price-time priority limit order book matcher with one buy and one sell
// book per instrument, all kept in one book entry memory.
//
// Channels: orders come in on "order", reports leave on "report", and the
// three limit registers are written on "cfg" (always ready). Each channel
// moves a transaction when valid and ready are both high.
// One order is worked on at a time. The quantity lot check runs in the
// remainder unit; sorted insertion then walks the book from its tail,
// reading each entry examined and writing it back one slot lower when it
// moves, then writes the new entry; each match reads both book tops,
// emits its reports and writes back the remainder.
// Removal from the top of a book is a head pointer step, so it costs nothing.
// Reports wait in an output register; while report.ready is low the block
// holds the report and takes no new order. The final report of an order
// carries last_report.
// Reset clears the fill counts, head pointers, serial counter and control
// state and restores the limits; book memory contents are left as they are
// and never read before written.
// ----------------------------------------------------------------------------
module limit_order_matcher (
	input  logic         clk,
	input  logic         arst_n,
	lom_order_if.sink    order,
	lom_report_if.source report,
	lom_cfg_if.sink      cfg
);

	lom_pkg::state_t state_q, state_d, ret_q, ret_d;

	// order registers
	logic [31:0]        o_client_q;
	logic [2:0]         o_instr_q;
	logic [7:0]         o_side_q;
	logic signed [15:0] o_qty_q;
	logic signed [31:0] o_price_q;
	logic [63:0]        o_stamp_q;
	logic [31:0]        serial_q, serial_d;

	// limits
	logic [lom_pkg::CFG_W-1:0] min_q, max_q, lot_q;

	// book control
	logic [lom_pkg::SLOT_W-1:0] head_q [lom_pkg::NBOOKS];
	logic [lom_pkg::SLOT_W-1:0] head_d [lom_pkg::NBOOKS];
	logic [lom_pkg::FILL_W-1:0] fill_q [lom_pkg::NBOOKS];
	logic [lom_pkg::FILL_W-1:0] fill_d [lom_pkg::NBOOKS];
	logic [lom_pkg::SLOT_W-1:0] idx_q, idx_d;
	logic [lom_pkg::RES_W-1:0]  nres_q, nres_d;
	logic                       pend_q, pend_d;
	lom_pkg::report_t           pend_rep_q, pend_rep_d;
	lom_pkg::report_t           rep_q, rep_d;

	// memory and remainder unit
	lom_pkg::mem_wr_t wr;
	lom_pkg::mem_rd_t rd_a, rd_b;
	lom_pkg::entry_t  data_a, data_b;
	logic             rem_busy;
	logic [lom_pkg::CFG_W-1:0] rem_val;
	logic             accept;

	// combinational helpers
	logic [lom_pkg::BOOK_W-1:0] cur_b, bb, sb;
	logic                       is_buy;
	logic                       qty_ok;
	lom_pkg::reject_reason_t    rsn;
	lom_pkg::entry_t            new_e, upd_e;
	lom_pkg::report_t           rep_rej, rep_new, rep_sell, rep_buy;
	logic signed [15:0]         mq;
	logic                       worse, more;

	assign accept = order.valid && order.ready;

	lom_mem u_mem (
		.clk    (clk),
		.wr     (wr),
		.rd_a   (rd_a),
		.rd_b   (rd_b),
		.data_a (data_a),
		.data_b (data_b)
	);

	lom_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (order.order_quantity[lom_pkg::CFG_W-1:0]),
		.divisor   (lot_q),
		.busy      (rem_busy),
		.remainder (rem_val)
	);

	// books of the current order
	assign is_buy = (o_side_q == lom_pkg::SIDE_BUY);
	assign bb     = lom_pkg::BOOK_W'({o_instr_q, 1'b0});
	assign sb     = bb + 1'b1;
	assign cur_b  = is_buy ? bb : sb;

	// validation, the last failing check wins
	always_comb begin
		qty_ok = !o_qty_q[15] && (o_qty_q[14:0] >= min_q) && (o_qty_q[14:0] <= max_q)
			&& ((lot_q == '0) || (rem_val == '0));
		rsn = lom_pkg::RSN_NONE;
		if (int'(o_instr_q) >= lom_pkg::NUM_INSTRUMENTS) rsn = lom_pkg::RSN_INSTRUMENT;
		if (o_side_q != lom_pkg::SIDE_BUY && o_side_q != lom_pkg::SIDE_SELL)
			rsn = lom_pkg::RSN_SIDE;
		if (!qty_ok) rsn = lom_pkg::RSN_QUANTITY;
		if (o_price_q <= 0) rsn = lom_pkg::RSN_PRICE;
	end

	// report templates
	always_comb begin
		new_e = '{price: o_price_q, qty: o_qty_q, serial: serial_q,
			client: o_client_q, stamp: o_stamp_q};
		rep_new = '{serial: serial_q, client: o_client_q, instr: o_instr_q,
			side: o_side_q, status: lom_pkg::ST_NEW, qty: o_qty_q, price: o_price_q,
			stamp: o_stamp_q, reason: lom_pkg::RSN_NONE, last: 1'b1};
		rep_rej = rep_new;
		rep_rej.status = lom_pkg::ST_REJECT;
		mq = (data_b.qty < data_a.qty) ? data_b.qty : data_a.qty;
		rep_sell = '{serial: data_b.serial, client: data_b.client, instr: o_instr_q,
			side: lom_pkg::SIDE_SELL,
			status: (data_b.qty > data_a.qty) ? lom_pkg::ST_PFILL : lom_pkg::ST_FILL,
			qty: mq, price: data_a.price, stamp: data_b.stamp,
			reason: lom_pkg::RSN_NONE, last: 1'b0};
		rep_buy = '{serial: data_a.serial, client: data_a.client, instr: o_instr_q,
			side: lom_pkg::SIDE_BUY,
			status: (data_b.qty < data_a.qty) ? lom_pkg::ST_PFILL : lom_pkg::ST_FILL,
			qty: mq, price: data_a.price, stamp: data_a.stamp,
			reason: lom_pkg::RSN_NONE, last: 1'b0};
		worse = is_buy ? (data_a.price < o_price_q) : (data_a.price > o_price_q);
		more  = (fill_q[bb] != '0) && (fill_q[sb] != '0)
			&& (int'(nres_q) + 2 <= lom_pkg::MAX_RESULTS);
		upd_e = (data_b.qty < data_a.qty) ? data_a : data_b;
		upd_e.qty = (data_b.qty < data_a.qty) ? (data_a.qty - data_b.qty)
			: (data_b.qty - data_a.qty);
	end

	// next state and outputs
	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		serial_d   = serial_q;
		head_d     = head_q;
		fill_d     = fill_q;
		idx_d      = idx_q;
		nres_d     = nres_q;
		pend_d     = pend_q;
		pend_rep_d = pend_rep_q;
		rep_d      = rep_q;
		wr         = '0;
		rd_a       = '0;
		rd_b       = '0;
		order.ready  = 1'b0;
		report.valid = 1'b0;
		case (state_q)
			lom_pkg::S_IDLE: begin
				order.ready = 1'b1;
				if (order.valid) begin
					serial_d = serial_q + 32'd1;
					state_d  = lom_pkg::S_CHECK;
				end
			end
			lom_pkg::S_CHECK: begin
				if (!rem_busy) begin
					if (rsn != lom_pkg::RSN_NONE) begin
						rep_d        = rep_rej;
						rep_d.reason = rsn;
						ret_d        = lom_pkg::S_IDLE;
						state_d      = lom_pkg::S_EMIT;
					end else if (fill_q[cur_b] == lom_pkg::FILL_W'(lom_pkg::BOOK_DEPTH)) begin
						rep_d        = rep_rej;
						rep_d.reason = lom_pkg::RSN_BOOK_FULL;
						ret_d        = lom_pkg::S_IDLE;
						state_d      = lom_pkg::S_EMIT;
					end else if (fill_q[cur_b] == '0) begin
						idx_d   = '0;
						state_d = lom_pkg::S_INS_NEW;
					end else begin
						idx_d   = lom_pkg::SLOT_W'(fill_q[cur_b] - 1'b1);
						state_d = lom_pkg::S_INS_RD;
					end
				end
			end
			// walk from the tail, moving strictly worse entries one slot down
			lom_pkg::S_INS_RD: begin
				rd_a.en   = 1'b1;
				rd_a.addr = lom_pkg::entry_addr(cur_b,
					lom_pkg::slot_add(head_q[cur_b], idx_q));
				state_d   = lom_pkg::S_INS_CHK;
			end
			lom_pkg::S_INS_CHK: begin
				if (worse) begin
					wr.en   = 1'b1;
					wr.addr = lom_pkg::entry_addr(cur_b,
						lom_pkg::slot_add(head_q[cur_b], idx_q + 1'b1));
					wr.data = data_a;
					if (idx_q == '0) begin
						state_d = lom_pkg::S_INS_NEW;
					end else begin
						idx_d   = idx_q - 1'b1;
						state_d = lom_pkg::S_INS_RD;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = lom_pkg::S_INS_NEW;
				end
			end
			lom_pkg::S_INS_NEW: begin
				wr.en   = 1'b1;
				wr.addr = lom_pkg::entry_addr(cur_b,
					lom_pkg::slot_add(head_q[cur_b], idx_q));
				wr.data = new_e;
				fill_d[cur_b] = fill_q[cur_b] + 1'b1;
				nres_d  = '0;
				pend_d  = 1'b0;
				state_d = lom_pkg::S_MATCH_RD;
			end
			// read both tops, or finish the order
			lom_pkg::S_MATCH_RD: begin
				if (more) begin
					rd_a.en   = 1'b1;
					rd_a.addr = lom_pkg::entry_addr(bb, head_q[bb]);
					rd_b.en   = 1'b1;
					rd_b.addr = lom_pkg::entry_addr(sb, head_q[sb]);
					state_d   = lom_pkg::S_MATCH_CHK;
				end else begin
					rep_d      = pend_q ? pend_rep_q : rep_new;
					rep_d.last = 1'b1;
					pend_d     = 1'b0;
					ret_d      = lom_pkg::S_IDLE;
					state_d    = lom_pkg::S_EMIT;
				end
			end
			lom_pkg::S_MATCH_CHK: begin
				if (data_b.price > data_a.price) begin
					rep_d      = pend_q ? pend_rep_q : rep_new;
					rep_d.last = 1'b1;
					pend_d     = 1'b0;
					ret_d      = lom_pkg::S_IDLE;
				end else if (pend_q) begin
					// previous buy side goes out before the next match
					rep_d  = pend_rep_q;
					pend_d = 1'b0;
					ret_d  = lom_pkg::S_MATCH_CHK;
				end else begin
					rep_d      = rep_sell;
					pend_rep_d = rep_buy;
					ret_d      = lom_pkg::S_MATCH_UPD;
				end
				state_d = lom_pkg::S_EMIT;
			end
			// write back the remainder and pop filled tops
			lom_pkg::S_MATCH_UPD: begin
				if (data_b.qty != data_a.qty) begin
					wr.en   = 1'b1;
					wr.addr = (data_b.qty < data_a.qty)
						? lom_pkg::entry_addr(bb, head_q[bb])
						: lom_pkg::entry_addr(sb, head_q[sb]);
					wr.data = upd_e;
				end
				if (data_b.qty <= data_a.qty) begin
					head_d[sb] = lom_pkg::slot_add(head_q[sb], lom_pkg::SLOT_W'(1));
					fill_d[sb] = fill_q[sb] - 1'b1;
				end
				if (data_b.qty >= data_a.qty) begin
					head_d[bb] = lom_pkg::slot_add(head_q[bb], lom_pkg::SLOT_W'(1));
					fill_d[bb] = fill_q[bb] - 1'b1;
				end
				pend_d  = 1'b1;
				nres_d  = nres_q + lom_pkg::RES_W'(2);
				state_d = lom_pkg::S_MATCH_RD;
			end
			lom_pkg::S_EMIT: begin
				report.valid = 1'b1;
				if (report.ready) state_d = ret_q;
			end
			default: begin
				state_d = lom_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lom_pkg::S_IDLE;
			ret_q    <= lom_pkg::S_IDLE;
			serial_q <= '0;
			idx_q    <= '0;
			nres_q   <= '0;
			pend_q   <= 1'b0;
			for (int i = 0; i < lom_pkg::NBOOKS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			serial_q <= serial_d;
			idx_q    <= idx_d;
			nres_q   <= nres_d;
			pend_q   <= pend_d;
			head_q   <= head_d;
			fill_q   <= fill_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			o_client_q <= order.client_tag;
			o_instr_q  <= order.instrument_code;
			o_side_q   <= order.order_side;
			o_qty_q    <= order.order_quantity;
			o_price_q  <= order.limit_price;
			o_stamp_q  <= order.timestamp;
		end
		rep_q      <= rep_d;
		pend_rep_q <= pend_rep_d;
	end

	// configuration writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= lom_pkg::MIN_QTY_RST;
			max_q <= lom_pkg::MAX_QTY_RST;
			lot_q <= lom_pkg::LOT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				lom_pkg::CFG_MIN_QTY: min_q <= cfg.data;
				lom_pkg::CFG_MAX_QTY: max_q <= cfg.data;
				lom_pkg::CFG_LOT:     lot_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// report port
	assign report.serial_number   = rep_q.serial;
	assign report.client_out      = rep_q.client;
	assign report.instrument_out  = rep_q.instr;
	assign report.side_out        = rep_q.side;
	assign report.exec_status     = rep_q.status;
	assign report.report_quantity = rep_q.qty;
	assign report.report_price    = rep_q.price;
	assign report.time_out        = rep_q.stamp;
	assign report.reject_reason   = rep_q.reason;
	assign report.last_report     = rep_q.last;

	// checks
	a_serial_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (serial_q == $past(serial_q) + 32'd1))
		else $error("serial counter did not step on an order");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> !order.ready)
		else $error("order taken while a report is pending");

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && report.exec_status == lom_pkg::ST_REJECT)
		|-> (report.last_report && report.reject_reason != lom_pkg::RSN_NONE))
		else $error("reject report without reason or last mark");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q[0]) <= lom_pkg::BOOK_DEPTH)
		else $error("book fill count beyond depth");

endmodule
